@@ hdl/mtmf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multichannel trimmed mean filter.
// Depends on nothing; every other file of the block imports it.
package mtmf_pkg;

	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 8;
	localparam int DLY_W      = 10;
	localparam int MAP_W      = 32;
	localparam int MASK_W     = 16;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ON   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_OFF  = 2'd2;

	localparam logic [1:0] CLASS_SHORT = 2'd0;
	localparam logic [1:0] CLASS_MID   = 2'd1;

	localparam logic [2:0] REG_WIN_SHORT = 3'd0;
	localparam logic [2:0] REG_WIN_MID   = 3'd1;
	localparam logic [2:0] REG_WIN_LONG  = 3'd2;
	localparam logic [2:0] REG_CLASS_MAP = 3'd3;
	localparam logic [2:0] REG_TEN_BIT   = 3'd4;
	localparam logic [2:0] REG_DELAY     = 3'd5;
	localparam logic [2:0] REG_SETTLE    = 3'd6;

	localparam logic [CNT_W-1:0]  MIN_WINDOW     = 8'd3;
	localparam logic [CNT_W-1:0]  WIN_SHORT_RST  = 8'd6;
	localparam logic [CNT_W-1:0]  WIN_MID_RST    = 8'd12;
	localparam logic [CNT_W-1:0]  WIN_LONG_RST   = 8'd52;
	localparam logic [MAP_W-1:0]  CLASS_MAP_RST  = 32'hA6A2_AAA0;
	localparam logic [MASK_W-1:0] TEN_BIT_RST    = 16'hFDC0;
	localparam logic [MASK_W-1:0] DELAY_MASK_RST = 16'h0018;
	localparam logic [DLY_W-1:0]  SETTLE_RST     = 10'd1000;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [CNT_W-1:0]  win_short;
		logic [CNT_W-1:0]  win_mid;
		logic [CNT_W-1:0]  win_long;
		logic [MAP_W-1:0]  class_map;
		logic [MASK_W-1:0] ten_bit_mask;
		logic [MASK_W-1:0] delay_slot_mask;
		logic [DLY_W-1:0]  settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/mtmf_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample words and result words.
// Depends on mtmf_pkg for the field widths.
interface mtmf_in_if import mtmf_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                   valid;
	logic                   ready;
	logic [FUNC_W-1:0]      func;
	logic [SLOT_W-1:0]      slot;
	logic [SAMPLE_BITS-1:0] raw_sample;

	modport source (output valid, func, slot, raw_sample, input ready);
	modport sink (input valid, func, slot, raw_sample, output ready);
endinterface

interface mtmf_out_if import mtmf_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                   valid;
	logic                   ready;
	logic [SLOT_W-1:0]      out_slot;
	logic [SAMPLE_BITS-1:0] average;

	modport source (output valid, out_slot, average, input ready);
	modport sink (input valid, out_slot, average, output ready);
endinterface

@@ hdl/multichannel_trimmed_mean_filter.sv @@
`timescale 1ns / 1ps
// Top level of the multichannel trimmed mean filter: configuration registers
// on an APB-style port, front end, window queue and divider back end.
// Depends on mtmf_pkg, mtmf_if, mtmf_front, mtmf_queue and mtmf_back.
//
// The front end takes one sample word per clock cycle and updates the addressed
// slot in that same cycle; it holds ready low only while the two-entry window
// queue is full. Each completed window then passes through the back end: a load
// step, the radix-2 divider and a step to post the result word, which waits
// while the last result word has not been taken. So a stream in which every
// word completes a window is paced by the divider. There is no clearing pass
// after reset.
module multichannel_trimmed_mean_filter import mtmf_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	mtmf_in_if.sink               sample_ch,
	mtmf_out_if.source            result_ch
);

	localparam int ENTRY_W = SLOT_W + (SAMPLE_BITS + CNT_W) + (SAMPLE_BITS + 1)
		+ SAMPLE_BITS + CNT_W;

	cfg_t               cfg_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;
	logic               front_push;
	logic               back_pop;
	q_req_t             q_req;
	q_stat_t            q_stat;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] pop_entry;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_short       <= WIN_SHORT_RST;
			cfg_q.win_mid         <= WIN_MID_RST;
			cfg_q.win_long        <= WIN_LONG_RST;
			cfg_q.class_map       <= CLASS_MAP_RST;
			cfg_q.ten_bit_mask    <= TEN_BIT_RST;
			cfg_q.delay_slot_mask <= DELAY_MASK_RST;
			cfg_q.settle_ticks    <= SETTLE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIN_SHORT: cfg_q.win_short       <= pwdata[CNT_W-1:0];
				REG_WIN_MID:   cfg_q.win_mid         <= pwdata[CNT_W-1:0];
				REG_WIN_LONG:  cfg_q.win_long        <= pwdata[CNT_W-1:0];
				REG_CLASS_MAP: cfg_q.class_map       <= pwdata[MAP_W-1:0];
				REG_TEN_BIT:   cfg_q.ten_bit_mask    <= pwdata[MASK_W-1:0];
				REG_DELAY:     cfg_q.delay_slot_mask <= pwdata[MASK_W-1:0];
				REG_SETTLE:    cfg_q.settle_ticks    <= pwdata[DLY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIN_SHORT: prdata = CFG_DATA_W'(cfg_q.win_short);
			REG_WIN_MID:   prdata = CFG_DATA_W'(cfg_q.win_mid);
			REG_WIN_LONG:  prdata = CFG_DATA_W'(cfg_q.win_long);
			REG_CLASS_MAP: prdata = CFG_DATA_W'(cfg_q.class_map);
			REG_TEN_BIT:   prdata = CFG_DATA_W'(cfg_q.ten_bit_mask);
			REG_DELAY:     prdata = CFG_DATA_W'(cfg_q.delay_slot_mask);
			REG_SETTLE:    prdata = CFG_DATA_W'(cfg_q.settle_ticks);
			default:       prdata = '0;
		endcase
	end

	assign q_req.push = front_push;
	assign q_req.pop  = back_pop;

	mtmf_front #(
		.NUM_SLOTS   (NUM_SLOTS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sample_ch (sample_ch),
		.q_stat    (q_stat),
		.push      (front_push),
		.entry     (push_entry)
	);

	mtmf_queue #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (q_req),
		.wr_data (push_entry),
		.rd_data (pop_entry),
		.stat    (q_stat)
	);

	mtmf_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (pop_entry),
		.q_stat    (q_stat),
		.pop       (back_pop),
		.result_ch (result_ch)
	);

endmodule

@@ hdl/mtmf_queue.sv @@
`timescale 1ns / 1ps
// Short queue of completed windows between the front end and the divider.
// Depends on mtmf_pkg for the depth and the request and status structs.
module mtmf_queue import mtmf_pkg::*; #(
	parameter int DATA_W = 57
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_req_t            req,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data,
	output q_stat_t           stat
);

	logic [DATA_W-1:0]  mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (req.pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (req.push && !req.pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (req.pop && !req.push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> (!stat.full || req.pop))
		else $error("Window pushed into a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> !stat.empty)
		else $error("Window popped from an empty queue.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("Queue fill count beyond its depth.");

endmodule

@@ hdl/mtmf_front.sv @@
`timescale 1ns / 1ps
// Front end: takes sample words, keeps per-slot window state and pushes
// completed windows into the queue. Depends on mtmf_pkg and mtmf_in_if.
module mtmf_front import mtmf_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int SAMPLE_BITS = 12,
	parameter int ENTRY_W     = 57
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	mtmf_in_if.sink            sample_ch,
	input  q_stat_t            q_stat,
	output logic               push,
	output logic [ENTRY_W-1:0] entry
);

	localparam int SUM_W      = SAMPLE_BITS + CNT_W;
	localparam int MIN_W      = SAMPLE_BITS + 1;
	localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [MIN_W-1:0] FS_FULL = MIN_W'(1) << SAMPLE_BITS;
	localparam logic [MIN_W-1:0] FS_TEN  = MIN_W'(1) << (SAMPLE_BITS - 2);
	localparam logic [31:0] TEN_RST32 = 32'(TEN_BIT_RST);
	localparam logic [31:0] DLY_RST32 = 32'(DELAY_MASK_RST);

	logic [SUM_W-1:0]       sum_q [NUM_SLOTS];
	logic [CNT_W-1:0]       count_q [NUM_SLOTS];
	logic [MIN_W-1:0]       min_q [NUM_SLOTS];
	logic [SAMPLE_BITS-1:0] max_q [NUM_SLOTS];
	logic [DLY_W-1:0]       delay_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   on_q;

	logic                   accepted;
	logic                   slot_ok;
	logic                   wr_en;
	logic [SLOT_IDX_W-1:0]  wr_idx;
	logic                   ten_bit;
	logic                   delayed;
	logic [1:0]             win_class;
	logic [CNT_W-1:0]       len_raw;
	logic [CNT_W-1:0]       len;
	logic [SAMPLE_BITS-1:0] value;
	logic [MIN_W-1:0]       full_scale;

	logic [SUM_W-1:0]       cur_sum;
	logic [CNT_W-1:0]       cur_cnt;
	logic [MIN_W-1:0]       cur_min;
	logic [SAMPLE_BITS-1:0] cur_max;
	logic [DLY_W-1:0]       cur_dly;
	logic                   cur_on;

	logic                   take;
	logic [SUM_W-1:0]       upd_sum;
	logic [CNT_W-1:0]       upd_cnt;
	logic [MIN_W-1:0]       upd_min;
	logic [SAMPLE_BITS-1:0] upd_max;

	logic [SUM_W-1:0]       nxt_sum;
	logic [CNT_W-1:0]       nxt_cnt;
	logic [MIN_W-1:0]       nxt_min;
	logic [SAMPLE_BITS-1:0] nxt_max;
	logic [DLY_W-1:0]       nxt_dly;
	logic                   nxt_on;

	assign sample_ch.ready = !q_stat.full;
	assign accepted = sample_ch.valid && sample_ch.ready;
	assign slot_ok  = (32'(sample_ch.slot) < 32'(NUM_SLOTS));
	assign wr_idx   = SLOT_IDX_W'(sample_ch.slot);
	assign wr_en    = accepted && slot_ok && (sample_ch.func == FUNC_TICK ||
		sample_ch.func == FUNC_ON || sample_ch.func == FUNC_OFF);

	assign ten_bit   = cfg.ten_bit_mask[sample_ch.slot];
	assign delayed   = cfg.delay_slot_mask[sample_ch.slot];
	assign win_class = cfg.class_map[{sample_ch.slot, 1'b0} +: 2];

	always_comb begin
		priority if (win_class == CLASS_SHORT) begin
			len_raw = cfg.win_short;
		end else if (win_class == CLASS_MID) begin
			len_raw = cfg.win_mid;
		end else begin
			len_raw = cfg.win_long;
		end
	end

	assign len        = (len_raw < MIN_WINDOW) ? MIN_WINDOW : len_raw;
	assign value      = ten_bit ? (sample_ch.raw_sample >> 2) : sample_ch.raw_sample;
	assign full_scale = ten_bit ? FS_TEN : FS_FULL;

	assign cur_sum = sum_q[wr_idx];
	assign cur_cnt = count_q[wr_idx];
	assign cur_min = min_q[wr_idx];
	assign cur_max = max_q[wr_idx];
	assign cur_dly = delay_q[wr_idx];
	assign cur_on  = on_q[wr_idx];

	assign take    = (cur_cnt < len);
	assign upd_sum = take ? (cur_sum + SUM_W'(value)) : cur_sum;
	assign upd_cnt = take ? (cur_cnt + CNT_W'(1)) : cur_cnt;
	assign upd_min = (take && (MIN_W'(value) < cur_min)) ? MIN_W'(value) : cur_min;
	assign upd_max = (take && (value > cur_max)) ? value : cur_max;

	always_comb begin
		nxt_sum = cur_sum;
		nxt_cnt = cur_cnt;
		nxt_min = cur_min;
		nxt_max = cur_max;
		nxt_dly = cur_dly;
		nxt_on  = cur_on;
		push    = 1'b0;
		priority if (sample_ch.func == FUNC_ON) begin
			nxt_on = 1'b1;
		end else if (sample_ch.func == FUNC_OFF) begin
			nxt_on = 1'b0;
		end else if (!cur_on) begin
			nxt_sum = '0;
			nxt_cnt = '0;
			nxt_min = full_scale;
			nxt_max = '0;
			if (delayed) begin
				nxt_dly = cfg.settle_ticks;
			end
		end else if (delayed && cur_dly != '0) begin
			nxt_dly = cur_dly - DLY_W'(1);
		end else if (upd_cnt >= len) begin
			push    = wr_en;
			nxt_sum = '0;
			nxt_cnt = '0;
			nxt_min = full_scale;
			nxt_max = '0;
		end else begin
			nxt_sum = upd_sum;
			nxt_cnt = upd_cnt;
			nxt_min = upd_min;
			nxt_max = upd_max;
		end
	end

	assign entry = {sample_ch.slot, upd_sum, upd_min, upd_max, upd_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				sum_q[s]   <= '0;
				count_q[s] <= '0;
				min_q[s]   <= TEN_RST32[s] ? FS_TEN : FS_FULL;
				max_q[s]   <= '0;
				delay_q[s] <= DLY_RST32[s] ? SETTLE_RST : '0;
				on_q[s]    <= 1'b1;
			end
		end else if (wr_en) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (wr_idx == SLOT_IDX_W'(s)) begin
					sum_q[s]   <= nxt_sum;
					count_q[s] <= nxt_cnt;
					min_q[s]   <= nxt_min;
					max_q[s]   <= nxt_max;
					delay_q[s] <= nxt_dly;
					on_q[s]    <= nxt_on;
				end
			end
		end
	end

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q[$past(wr_idx)] == '0)
		else $error("Slot not cleared after its window completed.");

	a_push_full_window: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (upd_cnt >= MIN_WINDOW && cur_on))
		else $error("Window pushed with fewer than three samples.");

	a_turn_on: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && sample_ch.func == FUNC_ON) |=> on_q[$past(wr_idx)])
		else $error("Slot did not turn on.");

endmodule

@@ hdl/mtmf_back.sv @@
`timescale 1ns / 1ps
// Back end: pops completed windows, trims and divides them one quotient bit
// per cycle and holds the result word. Depends on mtmf_pkg and mtmf_out_if.
module mtmf_back import mtmf_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int ENTRY_W     = 57
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENTRY_W-1:0] q_data,
	input  q_stat_t            q_stat,
	output logic               pop,
	mtmf_out_if.source         result_ch
);

	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int MIN_W  = SAMPLE_BITS + 1;
	localparam int ITER_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t            state_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W-1:0]       den_q;
	logic [ITER_W-1:0]      iter_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   out_valid_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;

	logic [SLOT_W-1:0]      e_slot;
	logic [SUM_W-1:0]       e_sum;
	logic [MIN_W-1:0]       e_min;
	logic [SAMPLE_BITS-1:0] e_max;
	logic [CNT_W-1:0]       e_cnt;
	logic [SUM_W-1:0]       numer;
	logic [CNT_W:0]         trial;
	logic                   fits;
	logic                   load_out;
	logic [SAMPLE_BITS-1:0] avg_sat;

	assign {e_slot, e_sum, e_min, e_max, e_cnt} = q_data;
	assign numer = e_sum - SUM_W'(e_min) - SUM_W'(e_max);

	assign pop   = (state_q == B_IDLE) && !q_stat.empty;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	assign load_out = (state_q == B_DONE) && (!out_valid_q || result_ch.ready);
	assign avg_sat  = (quo_q[SUM_W-1:SAMPLE_BITS] != '0) ? '1 : quo_q[SAMPLE_BITS-1:0];

	assign result_ch.valid    = out_valid_q;
	assign result_ch.out_slot = out_slot_q;
	assign result_ch.average  = out_avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						iter_q  <= ITER_W'(SUM_W - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					iter_q <= iter_q - ITER_W'(1);
					if (iter_q == '0) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q  <= numer;
			rem_q  <= '0;
			den_q  <= e_cnt - CNT_W'(2);
			slot_q <= e_slot;
		end else if (state_q == B_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
		if (load_out) begin
			out_slot_q <= slot_q;
			out_avg_q  <= avg_sat;
		end
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> den_q != '0)
		else $error("Divider running with a zero divisor.");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> rem_q < den_q)
		else $error("Partial remainder not below the divisor.");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == B_IDLE))
		else $error("Finished quotient not posted as a result word.");

endmodule
